// File: rtl/strip_band_peak_area_reader_unit_assert.svh
// ----------------------------------------------------------------------------
// strip band reader assertion macros
// concurrent checks on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef STRIP_BAND_PEAK_AREA_READER_UNIT_ASSERT_SVH
`define STRIP_BAND_PEAK_AREA_READER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SBPAR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SBPAR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBPAR_ASSERT_IMP(lbl, ante, cons, msg)
`define SBPAR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/sbpar_pkg.sv
// ----------------------------------------------------------------------------
// sbpar_pkg
// shared types and constants of the strip band peak area reader
// ----------------------------------------------------------------------------
package sbpar_pkg;

    localparam int PROFILE_DEPTH = 1024;
    localparam int ADDR_W        = $clog2(PROFILE_DEPTH);
    localparam int BAND_COUNT    = 13;
    localparam int BAND_W        = 4;
    localparam int PIX_W         = 8;
    localparam int POS_W         = 12;
    localparam int AREA_W        = 18;
    localparam int LOC_W         = 10;
    localparam int OUT_AREA_W    = 16;

    localparam int SCAN_LAST       = 600;
    localparam int WINDOW_HALF     = 15;
    localparam int LATE_LIMIT      = 52;
    localparam int END_CLAMP_AT    = 590;
    localparam int END_CLAMP_TO    = 595;
    localparam int RELOCATE_GAP    = 33;
    localparam int NEAR_EDGE_SHIFT = 18;
    localparam int MIN_SPAN        = 40;
    localparam int MIN_BACK        = 10;
    localparam int EDGE_TAPS       = 5;
    localparam int LOC_MAX         = 1023;
    localparam int AREA_MAX        = 65535;

    // x/3 as (x*683)>>11, exact for x <= 765
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;
    // x/5 as (x*3277)>>14, exact for x < 2048
    localparam int RECIP5       = 3277;
    localparam int RECIP5_SHIFT = 14;

    typedef enum logic [1:0] {
        REG_SCAN_START     = 2'd0,
        REG_REACTION_LIMIT = 2'd1,
        REG_REVERSE_LIMIT  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  scan_start;
        logic [15:0] reaction_limit;
        logic [9:0]  reverse_limit;
    } cfg_t;

    typedef struct packed {
        logic               positive;
        logic               chip_ok;
        logic [OUT_AREA_W-1:0] area;
        logic [LOC_W-1:0]   location;
        logic [BAND_W-1:0]  band;
        logic               final_band;
    } res_t;

endpackage

// File: rtl/sbpar_profile_ram.sv
// ----------------------------------------------------------------------------
// sbpar_profile_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sbpar_profile_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/sbpar_engine.sv
// ----------------------------------------------------------------------------
// sbpar_engine
// band search, minimum location and area integration over the profile ram
// ----------------------------------------------------------------------------
module sbpar_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  sbpar_pkg::cfg_t            cfg,
    output logic [sbpar_pkg::ADDR_W-1:0] rd_addr,
    input  logic [sbpar_pkg::PIX_W-1:0]  rd_data,
    output logic                       busy,
    output logic                       res_valid,
    input  logic                       res_ready,
    output sbpar_pkg::res_t            res
);

    localparam int PW = sbpar_pkg::POS_W;
    localparam int NB = sbpar_pkg::BAND_COUNT;
    localparam int BW = sbpar_pkg::BAND_W;
    localparam int AW = sbpar_pkg::AREA_W;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_REF, S_SCAN_RD, S_SCAN_EV, S_CHECK,
        S_LM_INIT, S_LM_RD, S_LM_EV, S_LM_DIV, S_LM_RND,
        S_AR_START, S_AR_EDGE_RD, S_AR_EDGE_EV, S_AR_BASE, S_AR_MEAN,
        S_AR_SUM_RD, S_AR_SUM_EV, S_AR_STORE, S_EMIT
    } state_t;

    state_t state_reg;

    logic [7:0]           ref_reg;
    logic signed [PW-1:0] i_reg;
    logic [BW-1:0]        idx_reg;
    logic                 first_reg;
    logic                 dark_reg;
    logic signed [PW-1:0] lo_reg;
    logic signed [PW-1:0] wfi_reg [NB];
    logic signed [PW-1:0] wf_reg [NB];
    logic signed [PW-1:0] loc_reg [NB];
    logic [AW-1:0]        area_reg [NB];

    logic signed [PW-1:0] p_reg;
    logic [5:0]           lm_cnt_reg;
    logic [7:0]           best_reg;
    logic                 have_reg;
    logic [9:0]           where_reg;
    logic [7:0]           lm_q_reg;
    logic                 lm_band0_reg;

    logic [BW-1:0]        k_reg;
    logic signed [PW-1:0] lp_reg;
    logic signed [PW-1:0] rp_reg;
    logic [3:0]           e_reg;
    logic [10:0]          left_reg;
    logic [10:0]          right_reg;
    logic [7:0]           l5_reg;
    logic [7:0]           r5_reg;
    logic [7:0]           base_reg;
    logic signed [PW-1:0] j_reg;
    logic [AW-1:0]        sum_reg;
    logic                 ok_reg;
    logic [1:0]           cnt_reg;

    logic                 out_valid_reg;
    sbpar_pkg::res_t      out_reg;
    logic                 inr_reg;

    logic signed [PW-1:0] xs_pos;
    logic signed [PW-1:0] rd_pos_c;
    logic signed [PW-1:0] edge_pos_c;
    logic [7:0]           sample_c;
    logic                 dark_c;
    logic signed [PW-1:0] wf_cur_c;
    logic signed [PW-1:0] centre_c;
    logic [9:0]           rem_full_c;
    logic [2:0]           rem_c;
    logic signed [PW-1:0] round_c;
    logic [21:0]          lm_prod_c;
    logic [22:0]          l_prod_c;
    logic [22:0]          r_prod_c;
    logic [8:0]           mean_sum_c;
    logic signed [PW-1:0] loc_k_c;
    logic signed [PW-1:0] wf_k_c;
    logic [AW-1:0]        react_c;

    assign xs_pos     = $signed(PW'(cfg.scan_start));
    assign sample_c   = inr_reg ? rd_data : 8'd0;
    assign dark_c     = ({1'b0, sample_c} + 9'd2) < {1'b0, ref_reg};
    assign wf_cur_c   = (idx_reg < BW'(NB)) ? wf_reg[idx_reg] : '0;
    assign centre_c   = (int'(i_reg) - sbpar_pkg::WINDOW_HALF <= int'(xs_pos)) ?
                        PW'(int'(xs_pos) + sbpar_pkg::NEAR_EDGE_SHIFT) : i_reg;
    assign edge_pos_c = (int'(e_reg) < sbpar_pkg::EDGE_TAPS) ?
                        PW'(int'(lp_reg) - 2 + int'(e_reg)) :
                        PW'(int'(rp_reg) - 7 + int'(e_reg));
    assign lm_prod_c  = 22'(where_reg) * 22'(sbpar_pkg::RECIP5);
    assign l_prod_c   = 23'(left_reg) * 23'(sbpar_pkg::RECIP5);
    assign r_prod_c   = 23'(right_reg) * 23'(sbpar_pkg::RECIP5);
    assign mean_sum_c = {1'b0, l5_reg} + {1'b0, r5_reg};
    assign rem_full_c = where_reg - 10'({2'b00, lm_q_reg} * 10'd5);
    assign rem_c      = rem_full_c[2:0];
    assign round_c    = (rem_c >= 3'd3) ? PW'(int'(where_reg) + 5 - int'(rem_c)) :
                                          PW'(int'(where_reg) - int'(rem_c));
    assign loc_k_c    = (k_reg < BW'(NB)) ? loc_reg[k_reg] : '0;
    assign wf_k_c     = (k_reg < BW'(NB)) ? wf_reg[k_reg] : '0;
    assign react_c    = AW'(cfg.reaction_limit);

    always_comb begin
        case (state_reg)
            S_START:      rd_pos_c = PW'(int'(xs_pos) - 2);
            S_SCAN_RD:    rd_pos_c = i_reg;
            S_LM_RD:      rd_pos_c = p_reg;
            S_AR_EDGE_RD: rd_pos_c = edge_pos_c;
            S_AR_SUM_RD:  rd_pos_c = j_reg;
            default:      rd_pos_c = i_reg;
        endcase
    end

    assign rd_addr = sbpar_pkg::ADDR_W'($unsigned(rd_pos_c));

    always_ff @(posedge aclk) begin
        // positions outside the store read as zero
        inr_reg <= !rd_pos_c[PW-1] && (int'(rd_pos_c) < sbpar_pkg::PROFILE_DEPTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < NB; n++) begin
                wfi_reg[n] <= '0;
                wf_reg[n]  <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    for (int n = 0; n < NB; n++) begin
                        loc_reg[n] <= '0;
                    end
                    idx_reg   <= BW'(1);
                    first_reg <= 1'b1;
                    state_reg <= S_REF;
                end
                S_REF: begin
                    ref_reg   <= sample_c;
                    i_reg     <= PW'(int'(xs_pos) + 2);
                    state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    if (int'(i_reg) > sbpar_pkg::SCAN_LAST || int'(idx_reg) > NB - 1) begin
                        k_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_AR_START;
                    end else begin
                        state_reg <= S_SCAN_EV;
                    end
                end
                S_SCAN_EV: begin
                    dark_reg <= dark_c;
                    if (first_reg && dark_c) begin
                        lm_band0_reg <= 1'b1;
                        state_reg    <= S_LM_INIT;
                    end else begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!first_reg && lo_reg <= i_reg && i_reg <= wf_cur_c) begin
                        if (int'(i_reg) > sbpar_pkg::END_CLAMP_AT) begin
                            k_reg     <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_AR_START;
                        end else if (dark_reg) begin
                            lm_band0_reg <= 1'b0;
                            state_reg    <= S_LM_INIT;
                        end else begin
                            loc_reg[idx_reg] <= PW'(int'(wf_cur_c) - sbpar_pkg::WINDOW_HALF);
                            lo_reg           <= wf_cur_c;
                            idx_reg          <= BW'(idx_reg + 1'b1);
                            i_reg            <= PW'(i_reg + 1'b1);
                            state_reg        <= S_SCAN_RD;
                        end
                    end else begin
                        i_reg     <= PW'(i_reg + 1'b1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_LM_INIT: begin
                    p_reg      <= PW'(int'(centre_c) - sbpar_pkg::MIN_BACK);
                    lm_cnt_reg <= '0;
                    have_reg   <= 1'b0;
                    state_reg  <= S_LM_RD;
                end
                S_LM_RD: begin
                    state_reg <= S_LM_EV;
                end
                S_LM_EV: begin
                    // a new minimum must undercut the best by more than two
                    if (!have_reg || ({1'b0, sample_c} + 9'd2) < {1'b0, best_reg}) begin
                        best_reg  <= sample_c;
                        where_reg <= 10'($unsigned(p_reg));
                        have_reg  <= 1'b1;
                    end
                    p_reg      <= PW'(p_reg + 1'b1);
                    lm_cnt_reg <= 6'(lm_cnt_reg + 1'b1);
                    if (int'(lm_cnt_reg) == sbpar_pkg::MIN_SPAN - 1) begin
                        state_reg <= S_LM_DIV;
                    end else begin
                        state_reg <= S_LM_RD;
                    end
                end
                S_LM_DIV: begin
                    lm_q_reg  <= lm_prod_c[sbpar_pkg::RECIP5_SHIFT +: 8];
                    state_reg <= S_LM_RND;
                end
                S_LM_RND: begin
                    if (lm_band0_reg) begin
                        loc_reg[0] <= round_c;
                        if (int'(i_reg) > int'(xs_pos) + sbpar_pkg::LATE_LIMIT) begin
                            k_reg     <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_AR_START;
                        end else begin
                            for (int n = 0; n < NB; n++) begin
                                wfi_reg[n] <= PW'(int'(round_c) - sbpar_pkg::WINDOW_HALF
                                                  + 35 * n + ((n + 1) >> 1));
                                wf_reg[n]  <= PW'(int'(round_c) + sbpar_pkg::WINDOW_HALF
                                                  + 35 * n + ((n + 1) >> 1));
                            end
                            for (int n = 1; n < NB; n++) begin
                                loc_reg[n] <= PW'(int'(round_c) + 33 * n + ((n + 1) >> 1));
                            end
                            lo_reg    <= PW'(int'(round_c) + sbpar_pkg::WINDOW_HALF);
                            first_reg <= 1'b0;
                            state_reg <= S_CHECK;
                        end
                    end else begin
                        loc_reg[idx_reg] <= round_c;
                        if (int'(idx_reg) < NB - 2) begin
                            wfi_reg[BW'(idx_reg + 1'b1)] <= PW'(int'(round_c)
                                + sbpar_pkg::RELOCATE_GAP - sbpar_pkg::WINDOW_HALF);
                            wf_reg[BW'(idx_reg + 1'b1)]  <= PW'(int'(round_c)
                                + sbpar_pkg::RELOCATE_GAP + sbpar_pkg::WINDOW_HALF);
                        end
                        lo_reg    <= wf_cur_c;
                        idx_reg   <= BW'(idx_reg + 1'b1);
                        i_reg     <= PW'(i_reg + 1'b1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_AR_START: begin
                    if (loc_k_c == '0) begin
                        sum_reg   <= AW'(1);
                        state_reg <= S_AR_STORE;
                    end else begin
                        lp_reg    <= wfi_reg[k_reg];
                        rp_reg    <= (int'(wf_k_c) >= sbpar_pkg::END_CLAMP_AT) ?
                                     PW'(sbpar_pkg::END_CLAMP_TO) : wf_k_c;
                        e_reg     <= '0;
                        left_reg  <= '0;
                        right_reg <= '0;
                        state_reg <= S_AR_EDGE_RD;
                    end
                end
                S_AR_EDGE_RD: begin
                    state_reg <= S_AR_EDGE_EV;
                end
                S_AR_EDGE_EV: begin
                    if (int'(e_reg) < sbpar_pkg::EDGE_TAPS) begin
                        left_reg <= 11'(left_reg + 11'(sample_c));
                    end else begin
                        right_reg <= 11'(right_reg + 11'(sample_c));
                    end
                    e_reg <= 4'(e_reg + 1'b1);
                    if (int'(e_reg) == 2 * sbpar_pkg::EDGE_TAPS - 1) begin
                        state_reg <= S_AR_BASE;
                    end else begin
                        state_reg <= S_AR_EDGE_RD;
                    end
                end
                S_AR_BASE: begin
                    l5_reg    <= l_prod_c[sbpar_pkg::RECIP5_SHIFT +: 8];
                    r5_reg    <= r_prod_c[sbpar_pkg::RECIP5_SHIFT +: 8];
                    state_reg <= S_AR_MEAN;
                end
                S_AR_MEAN: begin
                    base_reg <= mean_sum_c[8:1];
                    j_reg    <= lp_reg;
                    sum_reg  <= '0;
                    if (lp_reg > rp_reg) begin
                        state_reg <= S_AR_STORE;
                    end else begin
                        state_reg <= S_AR_SUM_RD;
                    end
                end
                S_AR_SUM_RD: begin
                    state_reg <= S_AR_SUM_EV;
                end
                S_AR_SUM_EV: begin
                    if (sample_c < base_reg) begin
                        sum_reg <= AW'(sum_reg + AW'(base_reg - sample_c));
                    end
                    if (j_reg == rp_reg) begin
                        state_reg <= S_AR_STORE;
                    end else begin
                        j_reg     <= PW'(j_reg + 1'b1);
                        state_reg <= S_AR_SUM_RD;
                    end
                end
                S_AR_STORE: begin
                    area_reg[k_reg] <= sum_reg;
                    if (k_reg == '0) begin
                        ok_reg <= !((loc_reg[0] > $signed(PW'(cfg.reverse_limit)))
                                    || (sum_reg < react_c));
                    end
                    if (int'(k_reg) < NB - 1 && sum_reg > react_c && cnt_reg != 2'd2) begin
                        cnt_reg <= 2'(cnt_reg + 1'b1);
                    end
                    if (int'(k_reg) == NB - 1) begin
                        k_reg         <= '0;
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_EMIT;
                    end else begin
                        k_reg     <= BW'(k_reg + 1'b1);
                        state_reg <= S_AR_START;
                    end
                end
                S_EMIT: begin
                    if (!out_valid_reg) begin
                        out_valid_reg       <= 1'b1;
                        out_reg.band        <= k_reg;
                        out_reg.chip_ok     <= ok_reg;
                        out_reg.positive    <= (cnt_reg == 2'd2);
                        out_reg.final_band  <= (int'(k_reg) == NB - 1);
                        if (loc_k_c < 0) begin
                            out_reg.location <= '0;
                        end else if (int'(loc_k_c) > sbpar_pkg::LOC_MAX) begin
                            out_reg.location <= sbpar_pkg::LOC_W'(sbpar_pkg::LOC_MAX);
                        end else begin
                            out_reg.location <= sbpar_pkg::LOC_W'($unsigned(loc_k_c));
                        end
                        if (int'(area_reg[k_reg]) > sbpar_pkg::AREA_MAX) begin
                            out_reg.area <= sbpar_pkg::OUT_AREA_W'(sbpar_pkg::AREA_MAX);
                        end else begin
                            out_reg.area <= sbpar_pkg::OUT_AREA_W'(area_reg[k_reg]);
                        end
                    end else if (res_ready) begin
                        out_valid_reg <= 1'b0;
                        if (int'(k_reg) == NB - 1) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg <= BW'(k_reg + 1'b1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// File: rtl/strip_band_peak_area_reader_unit.sv
// ----------------------------------------------------------------------------
// strip_band_peak_area_reader_unit
// scan line brightness profile, band search and band area measurement
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata pixel rgb, s_tlast line end
//  m_        out  m_tvalid/m_tready  m_tdata band result, m_tlast final band
//  cfg_      in   cfg_we             cfg_index, cfg_wdata
//
//  pixels load at one beat per cycle while s_tready is high, written through
//  the profile ram port; after the line end beat the engine runs on the single
//  ram read port: it scans positions, locates band minima, integrates each
//  band area and then emits the result beats
//  after reset a clearing pass zeroes the profile store,
//  with s_tready low; cfg writes are taken during it
//  a stalled m_ beat holds the engine and keeps s_tready low
// ----------------------------------------------------------------------------
`include "strip_band_peak_area_reader_unit_assert.svh"

module strip_band_peak_area_reader_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // band, location, area, chip_ok, positive
    output logic        m_tlast,   // final_band
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int AW = sbpar_pkg::ADDR_W;

    sbpar_pkg::cfg_t cfg_reg;
    logic            clear_active_reg;
    logic [AW-1:0]   clear_addr_reg;
    logic [AW:0]     wpos_reg;

    logic            in_beat;
    logic            room;
    logic [9:0]      rgb_sum;
    logic [19:0]     rgb_prod;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic            eng_busy;
    logic            res_valid;
    sbpar_pkg::res_t res;

    assign s_tready = !clear_active_reg && !eng_busy;
    assign in_beat  = s_tvalid && s_tready;
    assign room     = (int'(wpos_reg) < sbpar_pkg::PROFILE_DEPTH);

    assign rgb_sum  = 10'(s_tdata[7:0]) + 10'(s_tdata[15:8]) + 10'(s_tdata[23:16]);
    assign rgb_prod = 20'(rgb_sum) * 20'(sbpar_pkg::RECIP3);

    assign ram_we    = clear_active_reg || (in_beat && room);
    assign ram_waddr = clear_active_reg ? clear_addr_reg : wpos_reg[AW-1:0];
    assign ram_wdata = clear_active_reg ? 8'd0 : rgb_prod[sbpar_pkg::RECIP3_SHIFT +: 8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_start     <= 8'd80;
            cfg_reg.reaction_limit <= 16'd11;
            cfg_reg.reverse_limit  <= 10'd200;
        end else if (cfg_we) begin
            case (cfg_index)
                sbpar_pkg::REG_SCAN_START:     cfg_reg.scan_start     <= cfg_wdata[7:0];
                sbpar_pkg::REG_REACTION_LIMIT: cfg_reg.reaction_limit <= cfg_wdata;
                sbpar_pkg::REG_REVERSE_LIMIT:  cfg_reg.reverse_limit  <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            wpos_reg         <= '0;
        end else begin
            if (clear_active_reg) begin
                clear_addr_reg <= AW'(clear_addr_reg + 1'b1);
                if (int'(clear_addr_reg) == sbpar_pkg::PROFILE_DEPTH - 1) begin
                    clear_active_reg <= 1'b0;
                end
            end
            if (in_beat) begin
                // the line end beat rewinds the write pointer for the next line
                if (s_tlast) begin
                    wpos_reg <= '0;
                end else if (room) begin
                    wpos_reg <= (AW + 1)'(wpos_reg + 1'b1);
                end
            end
        end
    end

    sbpar_profile_ram #(
        .DEPTH (sbpar_pkg::PROFILE_DEPTH),
        .WIDTH (sbpar_pkg::PIX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sbpar_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_beat && s_tlast),
        .cfg       (cfg_reg),
        .rd_addr   (ram_raddr),
        .rd_data   (ram_rdata),
        .busy      (eng_busy),
        .res_valid (res_valid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {res.positive, res.chip_ok, res.area, res.location, res.band};
    assign m_tlast  = res.final_band;

    `SBPAR_ASSERT_NXT(a_line_end_blocks_input, in_beat && s_tlast, !s_tready, "beat after end")
    `SBPAR_ASSERT_IMP(a_emit_blocks_input, m_tvalid, !s_tready, "ready while emitting")
    `SBPAR_ASSERT_IMP(a_clear_quiet, clear_active_reg, !m_tvalid && !eng_busy, "busy in clear")

endmodule

// File: tb/tb_strip_band_peak_area_reader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strip_band_peak_area_reader_unit
// feeds scan lines of rgb pixels, mostly synthetic strips with dark bands at
// band pitch, predicts the 13 band results of every line in the bench and
// compares each m_ beat field by field, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_strip_band_peak_area_reader_unit;

    typedef struct {
        logic [3:0]  band;
        logic [9:0]  location;
        logic [15:0] area;
        logic        chip_ok;
        logic        positive;
        logic        final_band;
    } band_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    strip_band_peak_area_reader_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // predictor state
    logic [7:0]   brightness [sbpar_pkg::PROFILE_DEPTH];
    int           fill_pos;
    int           win_first [sbpar_pkg::BAND_COUNT];
    int           win_last  [sbpar_pkg::BAND_COUNT];
    int           band_loc  [sbpar_pkg::BAND_COUNT];
    int           cfg_start;
    int           cfg_reaction;
    int           cfg_reverse;
    band_result_t band_results_q [$];

    int  error_count;
    bit  calm;          // no idling on either side
    int  hold_request;  // long receiver hold-off, in cycles
    int  line_level [0:1039];
    int  line_len;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic int sample(int p);
        if (p < 0 || p >= sbpar_pkg::PROFILE_DEPTH) return 0;
        return brightness[p];
    endfunction

    function automatic int dip_position(int centre);
        int best, where, p, v, rem;
        best  = 9999;
        where = 0;
        if (centre - sbpar_pkg::WINDOW_HALF <= cfg_start)
            centre = cfg_start + sbpar_pkg::NEAR_EDGE_SHIFT;
        for (p = centre - 10; p < centre + 30; p++) begin
            v = sample(p);
            if (v < best - 2) begin
                best  = v;
                where = p;
            end
        end
        rem = where % 5;
        if (rem < 0) rem += 5;
        if (rem >= 3) where += 5 - rem;
        else where -= rem;
        return where;
    endfunction

    function automatic void locate_bands();
        int ref_level, i, j, idx, pitch;
        bit searching;
        idx = 1;
        searching = 1'b1;
        for (j = 0; j < sbpar_pkg::BAND_COUNT; j++) band_loc[j] = 0;
        ref_level = sample(cfg_start - 2);
        for (i = cfg_start + 2; i <= sbpar_pkg::SCAN_LAST; i++) begin
            if (idx > sbpar_pkg::BAND_COUNT - 1) return;
            if (searching && sample(i) < ref_level - 2) begin
                band_loc[0] = dip_position(i);
                // late first band: later windows stay as they were
                if (i > cfg_start + sbpar_pkg::LATE_LIMIT) return;
                win_first[0] = band_loc[0] - sbpar_pkg::WINDOW_HALF;
                win_last[0]  = band_loc[0] + sbpar_pkg::WINDOW_HALF;
                for (j = 1; j < sbpar_pkg::BAND_COUNT; j++) begin
                    pitch = (j % 2 == 0) ? 33 : 34;
                    win_first[j] = win_first[j-1] + pitch;
                    win_last[j]  = win_last[j-1] + pitch;
                    band_loc[j]  = band_loc[j-1] + pitch;
                end
                for (j = 1; j < sbpar_pkg::BAND_COUNT; j++) begin
                    win_first[j] += 2 * j;
                    win_last[j]  += 2 * j;
                end
                searching = 1'b0;
            end
            if (!searching && win_last[idx-1] <= i && i <= win_last[idx]) begin
                if (i > sbpar_pkg::END_CLAMP_AT) return;
                if (sample(i) < ref_level - 2) begin
                    band_loc[idx] = dip_position(i);
                    if (idx < sbpar_pkg::BAND_COUNT - 2) begin
                        win_first[idx+1] = band_loc[idx] + sbpar_pkg::RELOCATE_GAP
                                           - sbpar_pkg::WINDOW_HALF;
                        win_last[idx+1]  = band_loc[idx] + sbpar_pkg::RELOCATE_GAP
                                           + sbpar_pkg::WINDOW_HALF;
                    end
                end else begin
                    band_loc[idx] = win_last[idx] - sbpar_pkg::WINDOW_HALF;
                end
                idx++;
            end
        end
    endfunction

    function automatic int deficit_area(int k);
        int lp, rp, left_sum, right_sum, base, total, j, v;
        if (band_loc[k] == 0) return 1;
        lp = win_first[k];
        rp = win_last[k];
        left_sum = 0;
        right_sum = 0;
        total = 0;
        if (rp >= sbpar_pkg::END_CLAMP_AT) rp = sbpar_pkg::END_CLAMP_TO;
        for (j = -2; j <= 2; j++) begin
            left_sum  += sample(lp + j);
            right_sum += sample(rp + j);
        end
        base = (left_sum / 5 + right_sum / 5) / 2;
        for (j = lp; j <= rp; j++) begin
            v = sample(j);
            if (v < base) total += base - v;
        end
        return total;
    endfunction

    function automatic void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic line_end);
        int areas [sbpar_pkg::BAND_COUNT];
        int k, hits, l, a;
        bit ok, pos;
        band_result_t res;
        if (fill_pos < sbpar_pkg::PROFILE_DEPTH) begin
            brightness[fill_pos] = 8'((int'(r) + int'(g) + int'(b)) / 3);
            fill_pos++;
        end
        if (!line_end) return;
        locate_bands();
        for (k = 0; k < sbpar_pkg::BAND_COUNT; k++) areas[k] = deficit_area(k);
        ok = !(band_loc[0] > cfg_reverse || areas[0] < cfg_reaction);
        hits = 0;
        for (k = 0; k < sbpar_pkg::BAND_COUNT - 1; k++) if (areas[k] > cfg_reaction) hits++;
        pos = (hits >= 2);
        for (k = 0; k < sbpar_pkg::BAND_COUNT; k++) begin
            l = band_loc[k];
            a = areas[k];
            if (l < 0) l = 0;
            if (l > sbpar_pkg::LOC_MAX) l = sbpar_pkg::LOC_MAX;
            if (a > sbpar_pkg::AREA_MAX) a = sbpar_pkg::AREA_MAX;
            if (a < 0) a = 0;
            res.band       = 4'(k);
            res.location   = 10'(l);
            res.area       = 16'(a);
            res.chip_ok    = ok;
            res.positive   = pos;
            res.final_band = (k == sbpar_pkg::BAND_COUNT - 1);
            band_results_q = {band_results_q, res};
        end
        fill_pos = 0;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    function automatic void note_error(string what);
        if (error_count < 10) $display("mismatch: %s", what);
        error_count++;
    endfunction

    logic        mon_valid, mon_ready, mon_last, mon_rst;
    logic [31:0] mon_data;
    int          stall_left;

    initial begin
        band_result_t exp_r;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            mon_valid = m_tvalid;
            mon_ready = m_tready;
            mon_data  = m_tdata;
            mon_last  = m_tlast;
            mon_rst   = aresetn;
            @(posedge aclk);
            if (mon_rst && mon_valid && mon_ready) begin
                if (band_results_q.size() == 0) begin
                    note_error($sformatf("unexpected beat data=%h last=%b", mon_data, mon_last));
                end else begin
                    exp_r = band_results_q.pop_front();
                    if (mon_data[3:0] !== exp_r.band)
                        note_error($sformatf("band exp %0d got %0d", exp_r.band, mon_data[3:0]));
                    if (mon_data[13:4] !== exp_r.location)
                        note_error($sformatf("band %0d location exp %0d got %0d",
                                             exp_r.band, exp_r.location, mon_data[13:4]));
                    if (mon_data[29:14] !== exp_r.area)
                        note_error($sformatf("band %0d area exp %0d got %0d",
                                             exp_r.band, exp_r.area, mon_data[29:14]));
                    if (mon_data[30] !== exp_r.chip_ok)
                        note_error($sformatf("band %0d chip_ok exp %b got %b",
                                             exp_r.band, exp_r.chip_ok, mon_data[30]));
                    if (mon_data[31] !== exp_r.positive)
                        note_error($sformatf("band %0d positive exp %b got %b",
                                             exp_r.band, exp_r.positive, mon_data[31]));
                    if (mon_last !== exp_r.final_band)
                        note_error($sformatf("band %0d tlast exp %b got %b",
                                             exp_r.band, exp_r.final_band, mon_last));
                end
            end
            // ready for the next cycle
            if (hold_request > 0) begin
                hold_request--;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic line_end);
        logic rdy;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        s_tlast  <= line_end;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        take_pixel(r, g, b, line_end);
    endtask

    // one pixel whose brightness is lvl, colour split at random
    task automatic send_level(int lvl, logic line_end);
        int s, r, g;
        s = 3 * lvl + $urandom_range(0, 2);
        if (s > 765) s = 765;
        r = $urandom_range(s > 510 ? s - 510 : 0, s > 255 ? 255 : s);
        s -= r;
        g = $urandom_range(s > 255 ? s - 255 : 0, s > 255 ? 255 : s);
        send_pixel(8'(r), 8'(g), 8'(s - g), line_end);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_len; i++) send_level(line_level[i], i == line_len - 1);
    endtask

    // bright strip with dark bands; first band offset past scan_start,
    // depth 0 leaves a band absent
    task automatic build_strip(int first_off, int len);
        int bg, i, k, c, depth, d, w;
        bg = $urandom_range(120, 250);
        line_len = len;
        for (i = 0; i < len; i++) line_level[i] = bg - $urandom_range(0, 2);
        c = cfg_start + first_off;
        for (k = 0; k < sbpar_pkg::BAND_COUNT && first_off >= 0; k++) begin
            depth = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(5, bg);
            w = $urandom_range(3, 9);
            for (d = -w; d <= w; d++)
                if (c + d >= 0 && c + d < len)
                    line_level[c + d] = bg - depth + (depth * (d < 0 ? -d : d)) / (w + 1);
            c += ((k % 2 == 0) ? 34 : 33) + 2 + $urandom_range(0, 4) - 2;
        end
    endtask

    task automatic write_reg(sbpar_pkg::cfg_index_t idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sbpar_pkg::REG_SCAN_START:     cfg_start    = value[7:0];
            sbpar_pkg::REG_REACTION_LIMIT: cfg_reaction = value;
            sbpar_pkg::REG_REVERSE_LIMIT:  cfg_reverse  = value[9:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (band_results_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_short_lines();
        // empty store: no first band, every location 0 and area 1
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'h80, 1'b1);
        send_pixel(8'h01, 8'h02, 8'h7F, 1'b1);
        wait_idle();
    endtask

    task automatic test_band_strips();
        int n;
        write_reg(sbpar_pkg::REG_SCAN_START, 16'd4);
        for (n = 0; n < 2; n++) begin
            build_strip($urandom_range(3, 8), $urandom_range(22, 26));
            send_line();
        end
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(sbpar_pkg::REG_SCAN_START, 16'd2);
        write_reg(sbpar_pkg::REG_REACTION_LIMIT, 16'd0);
        write_reg(sbpar_pkg::REG_REVERSE_LIMIT, 16'd1023);
        build_strip(4, 10);
        send_line();
        wait_idle();
        write_reg(sbpar_pkg::REG_SCAN_START, 16'd130);
        write_reg(sbpar_pkg::REG_REACTION_LIMIT, 16'hFFFF);
        write_reg(sbpar_pkg::REG_REVERSE_LIMIT, 16'd0);
        build_strip(20, 6);
        send_line();
        wait_idle();
        write_reg(sbpar_pkg::REG_SCAN_START, 16'd255);
        write_reg(sbpar_pkg::REG_REACTION_LIMIT, 16'd300);
        write_reg(sbpar_pkg::REG_REVERSE_LIMIT, 16'd400);
        build_strip(10, 4);
        send_line();
        wait_idle();
        write_reg(sbpar_pkg::REG_SCAN_START, 16'd80);
        write_reg(sbpar_pkg::REG_REACTION_LIMIT, 16'd11);
        write_reg(sbpar_pkg::REG_REVERSE_LIMIT, 16'd200);
    endtask

    task automatic test_special_strips();
        // late first band, then a strip with no band at all
        write_reg(sbpar_pkg::REG_SCAN_START, 16'd2);
        build_strip(62, 62);
        send_line();
        build_strip(-1, 8);
        send_line();
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_request = 8000;
        build_strip(2, 8);
        send_line();
        build_strip(3, 8);
        send_line();
        wait_idle();
    endtask

    task automatic test_random_lines();
        int n, i, len;
        for (n = 0; n < 2; n++) begin
            write_reg(sbpar_pkg::REG_SCAN_START, 16'($urandom_range(2, 130)));
            write_reg(sbpar_pkg::REG_REACTION_LIMIT, 16'($urandom_range(0, 2000)));
            write_reg(sbpar_pkg::REG_REVERSE_LIMIT, 16'($urandom_range(0, 1023)));
            build_strip($urandom_range(3, 50), $urandom_range(6, 8));
            send_line();
            // short noisy lines over the old strip contents
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == len - 1);
            wait_idle();
        end
    endtask

    task automatic test_calm_finish();
        calm = 1'b1;
        build_strip(3, 8);
        send_line();
        wait_idle();
    endtask

    initial begin
        error_count  = 0;
        calm         = 1'b0;
        hold_request = 0;
        fill_pos     = 0;
        cfg_start    = 80;
        cfg_reaction = 11;
        cfg_reverse  = 200;
        for (int i = 0; i < sbpar_pkg::PROFILE_DEPTH; i++) brightness[i] = 8'd0;
        for (int i = 0; i < sbpar_pkg::BAND_COUNT; i++) begin
            win_first[i] = 0;
            win_last[i]  = 0;
        end
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 24'd0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= sbpar_pkg::REG_SCAN_START;
        cfg_wdata <= 16'd0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_lines();
        test_band_strips();
        test_register_extremes();
        test_special_strips();
        test_backpressure();
        test_random_lines();
        test_calm_finish();

        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sbpar_pkg.sv
rtl/sbpar_profile_ram.sv
rtl/sbpar_engine.sv
rtl/strip_band_peak_area_reader_unit.sv
tb/tb_strip_band_peak_area_reader_unit.sv
